[design/i2c_ras_pkg.sv]
// ============================================================================
// I2C register access sequencer package
// Item types, bus status codes, action codes and register indexes shared by
// the sequencer and its checker.
// ============================================================================
`default_nettype none

package i2c_ras_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // Actions requested from the bus engine.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_NACK  = 3'd4;

  // Bus engine status codes, compared after masking the low three bits.
  localparam logic [7:0] STATUS_MASK  = 8'd248;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_DATA_NACK = 8'h58;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT   = 1'd1;
  localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd104;
  localparam logic [7:0] RETRY_LIMIT_RESET   = 8'd255;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] wr_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] rd_data;
  } rsp_t;

endpackage

`default_nettype wire

[design/i2c_register_access_sequencer.sv]
// An accepted item waits in the input register; its result is registered onto rsp_item
// once the result register is free to move on.
// Throughput: one item per cycle while rsp_stall is low; the input register refills whenever
// the result register moves on, and the result register is refilled in the cycle it is taken.
// Reset (rst, synchronous, active high) empties both registers, sets the step to idle,
// clears the held transfer state and loads slave_address 104 and retry_limit 255.
// ============================================================================
// I2C register access sequencer
// Steps one I2C master register write or register read through a two-wire
// bus engine, one request or bus status item at a time, with retries.
// ============================================================================
`default_nettype none

module i2c_register_access_sequencer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Request and status items.
  input  wire logic                                req_valid,
  output      logic                                req_stall,
  input  wire i2c_ras_pkg::req_t                   req_item,
  // Result items.
  output      logic                                rsp_valid,
  input  wire logic                                rsp_stall,
  output      i2c_ras_pkg::rsp_t                   rsp_item,
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic [i2c_ras_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                          cfg_data
);

  // The step records which bus phase the transfer is waiting on. A retry
  // repeats the action that belongs to the current step.
  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_START  = 3'd1,
    STEP_ADDR_W = 3'd2,
    STEP_REG    = 3'd3,
    STEP_DATA   = 3'd4,
    STEP_ADDR_R = 3'd5,
    STEP_NACK   = 3'd6
  } step_t;

  // Configuration registers.
  logic [6:0] slave_address;
  logic [7:0] retry_limit;

  // Transfer state and its next values.
  step_t      step, step_next;
  logic       is_write, is_write_next;
  logic       data_sent, data_sent_next;
  logic [7:0] held_reg_addr, held_reg_addr_next;
  logic [7:0] held_wr_byte, held_wr_byte_next;
  logic [7:0] retries_left, retries_left_next;

  // Input register, ahead of the step logic.
  logic              hold_valid;
  i2c_ras_pkg::req_t hold_item;

  // Result computed from the held item and the current state.
  i2c_ras_pkg::rsp_t rsp_next;

  logic       advance;
  logic       fire;
  logic [7:0] addr_w_byte;
  logic [7:0] addr_r_byte;
  logic [7:0] status_code;
  logic [7:0] retries_dec;

  // The result register moves on when it is empty or being taken. The held
  // item is processed in exactly that cycle, so the input register can
  // take a new item at the same edge.
  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = hold_valid && advance;
  assign req_stall = hold_valid && !advance;

  assign addr_w_byte = {slave_address, 1'b0};
  assign addr_r_byte = {slave_address, 1'b1};
  assign status_code = hold_item.bus_status & i2c_ras_pkg::STATUS_MASK;
  assign retries_dec = 8'(retries_left - 8'd1);

  always_comb begin
    step_next          = step;
    is_write_next      = is_write;
    data_sent_next     = data_sent;
    held_reg_addr_next = held_reg_addr;
    held_wr_byte_next  = held_wr_byte;
    retries_left_next  = retries_left;
    rsp_next           = '0;
    rsp_next.action    = i2c_ras_pkg::ACT_NONE;

    case (hold_item.op)
      i2c_ras_pkg::OP_WRITE, i2c_ras_pkg::OP_READ: begin
        // A start request always begins a fresh transfer, even over one
        // that is still in progress.
        is_write_next      = (hold_item.op == i2c_ras_pkg::OP_WRITE);
        held_reg_addr_next = hold_item.reg_addr;
        if (hold_item.op == i2c_ras_pkg::OP_WRITE) begin
          held_wr_byte_next = hold_item.wr_byte;
        end
        data_sent_next    = 1'b0;
        retries_left_next = retry_limit;
        step_next         = STEP_START;
        rsp_next.action   = i2c_ras_pkg::ACT_START;
      end
      i2c_ras_pkg::OP_STATUS: begin
        // Status events while idle are ignored.
        if (step != STEP_IDLE) begin
          case (status_code)
            i2c_ras_pkg::ST_START: begin
              rsp_next.action  = i2c_ras_pkg::ACT_SEND;
              rsp_next.tx_byte = addr_w_byte;
              step_next        = STEP_ADDR_W;
            end
            i2c_ras_pkg::ST_SLA_W_ACK: begin
              rsp_next.action  = i2c_ras_pkg::ACT_SEND;
              rsp_next.tx_byte = held_reg_addr;
              step_next        = STEP_REG;
              data_sent_next   = 1'b0;
            end
            i2c_ras_pkg::ST_DATA_ACK: begin
              if (data_sent) begin
                // The write byte was acknowledged: finish with a stop.
                rsp_next.action   = i2c_ras_pkg::ACT_STOP;
                rsp_next.done_res = 1'b1;
                step_next         = STEP_IDLE;
              end else if (is_write) begin
                rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                rsp_next.tx_byte = held_wr_byte;
                data_sent_next   = 1'b1;
                step_next        = STEP_DATA;
              end else begin
                // Register address sent for a read: repeated start.
                rsp_next.action = i2c_ras_pkg::ACT_START;
                step_next       = STEP_DATA;
              end
            end
            i2c_ras_pkg::ST_REP_START: begin
              rsp_next.action  = i2c_ras_pkg::ACT_SEND;
              rsp_next.tx_byte = addr_r_byte;
              step_next        = STEP_ADDR_R;
            end
            i2c_ras_pkg::ST_SLA_R_ACK: begin
              rsp_next.action = i2c_ras_pkg::ACT_NACK;
              step_next       = STEP_NACK;
            end
            i2c_ras_pkg::ST_DATA_NACK: begin
              rsp_next.action   = i2c_ras_pkg::ACT_STOP;
              rsp_next.done_res = 1'b1;
              rsp_next.rd_data  = hold_item.rx_byte;
              step_next         = STEP_IDLE;
            end
            default: begin
              // Unexpected status: spend one retry. A limit of zero wraps
              // the counter and keeps the transfer retrying.
              retries_left_next = retries_dec;
              if (retries_dec == 8'd0) begin
                rsp_next.action   = i2c_ras_pkg::ACT_STOP;
                rsp_next.done_res = 1'b1;
                rsp_next.failed   = 1'b1;
                step_next         = STEP_IDLE;
              end else begin
                case (step)
                  STEP_START: begin
                    rsp_next.action = i2c_ras_pkg::ACT_START;
                  end
                  STEP_ADDR_W: begin
                    rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                    rsp_next.tx_byte = addr_w_byte;
                  end
                  STEP_REG: begin
                    rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                    rsp_next.tx_byte = held_reg_addr;
                  end
                  STEP_DATA: begin
                    if (is_write) begin
                      rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                      rsp_next.tx_byte = held_wr_byte;
                    end else begin
                      rsp_next.action = i2c_ras_pkg::ACT_START;
                    end
                  end
                  STEP_ADDR_R: begin
                    rsp_next.action  = i2c_ras_pkg::ACT_SEND;
                    rsp_next.tx_byte = addr_r_byte;
                  end
                  STEP_NACK: begin
                    rsp_next.action = i2c_ras_pkg::ACT_NACK;
                  end
                  default: begin
                    rsp_next.action = i2c_ras_pkg::ACT_NONE;
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: begin
        // The unused op code gives an empty result and changes nothing.
        rsp_next.action = i2c_ras_pkg::ACT_NONE;
      end
    endcase
  end

  // Configuration registers. Writes should only arrive while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= i2c_ras_pkg::SLAVE_ADDRESS_RESET;
      retry_limit   <= i2c_ras_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2c_ras_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg_data[6:0];
        i2c_ras_pkg::CFG_RETRY_LIMIT:   retry_limit   <= cfg_data;
        default: begin
          slave_address <= slave_address;
        end
      endcase
    end
  end

  // Step state, input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_IDLE;
      is_write      <= 1'b0;
      data_sent     <= 1'b0;
      held_reg_addr <= 8'd0;
      held_wr_byte  <= 8'd0;
      retries_left  <= 8'd0;
      hold_valid    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (fire) begin
        step          <= step_next;
        is_write      <= is_write_next;
        data_sent     <= data_sent_next;
        held_reg_addr <= held_reg_addr_next;
        held_wr_byte  <= held_wr_byte_next;
        retries_left  <= retries_left_next;
        rsp_item      <= rsp_next;
      end
      if (advance) begin
        rsp_valid <= hold_valid;
      end
      if (!req_stall) begin
        hold_valid <= req_valid;
        hold_item  <= req_item;
      end
    end
  end

endmodule

`default_nettype wire

[design/i2c_ras_checker.sv]
// ============================================================================
// I2C register access sequencer checker
// Watches the result port of the sequencer and checks how result fields
// relate to each other and that a stalled result holds.
// ============================================================================
`default_nettype none

module i2c_ras_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire i2c_ras_pkg::rsp_t rsp_item
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed or was dropped");

  // An abort is always the end of a transfer.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.failed |-> rsp_item.done_res)
    else $error("failed flagged without done");

  // A transfer only ends with a stop.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.done_res |-> rsp_item.action == i2c_ras_pkg::ACT_STOP)
    else $error("transfer ended without a stop");

  // Read data only appears on a successful end.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.rd_data != 8'd0) |-> rsp_item.done_res && !rsp_item.failed)
    else $error("read data outside a successful end");

  // A byte to transmit only comes with a send action.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.tx_byte != 8'd0) |-> rsp_item.action == i2c_ras_pkg::ACT_SEND)
    else $error("tx byte without a send action");

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

`default_nettype wire

[dv/i2c_register_access_sequencer_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// I2C register access sequencer testbench
// Drives request and bus status items through the sequencer and checks every
// result item against an in-bench step predictor. The run covers directed
// transfers, retries, aborts, random traffic under sender gaps and receiver
// stalls, and one long receiver hold-off that fills the block.
// ============================================================================
`default_nettype none

module i2c_register_access_sequencer_test;

  // Transfer steps as the predictor tracks them.
  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_START, SEQ_SLA_W, SEQ_REG, SEQ_DATA, SEQ_SLA_R, SEQ_RX
  } seq_step_t;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 160;
  localparam int unsigned TAIL_CYCLES    = 8;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  i2c_ras_pkg::req_t                   req_item  = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b0;
  i2c_ras_pkg::rsp_t                   rsp_item;
  logic                                cfg_we    = 1'b0;
  logic [i2c_ras_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]                          cfg_data  = '0;

  i2c_register_access_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor copy of the configuration and the transfer state.
  logic [6:0] mdl_slave_addr;
  logic [7:0] mdl_retry_limit;
  seq_step_t  mdl_step;
  logic       mdl_is_write;
  logic       mdl_data_sent;
  logic [7:0] mdl_reg_addr;
  logic [7:0] mdl_wr_byte;
  logic [7:0] mdl_retries;

  i2c_ras_pkg::rsp_t expected_rsps[$];
  int unsigned       err_count     = 0;
  int unsigned       sent_items    = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       rsp_stall_pct = 0;
  int unsigned       quiet_cycles  = 0;
  logic              rsp_hold      = 1'b0;
  event              hold_off_go;

  function automatic void reset_predictor();
    mdl_slave_addr  = i2c_ras_pkg::SLAVE_ADDRESS_RESET;
    mdl_retry_limit = i2c_ras_pkg::RETRY_LIMIT_RESET;
    mdl_step        = SEQ_IDLE;
    mdl_is_write    = 1'b0;
    mdl_data_sent   = 1'b0;
    mdl_reg_addr    = '0;
    mdl_wr_byte     = '0;
    mdl_retries     = '0;
  endfunction

  // Advances the predicted transfer by one item and returns its result.
  function automatic i2c_ras_pkg::rsp_t predict_sequencer(input i2c_ras_pkg::req_t it);
    i2c_ras_pkg::rsp_t r;
    logic [7:0]        status;
    logic [7:0]        addr_w;
    r      = '0;
    status = it.bus_status & i2c_ras_pkg::STATUS_MASK;
    addr_w = {mdl_slave_addr, 1'b0};
    if (it.op == i2c_ras_pkg::OP_WRITE || it.op == i2c_ras_pkg::OP_READ) begin
      // A start always begins afresh, even in the middle of a transfer.
      mdl_is_write  = (it.op == i2c_ras_pkg::OP_WRITE);
      mdl_reg_addr  = it.reg_addr;
      if (it.op == i2c_ras_pkg::OP_WRITE) mdl_wr_byte = it.wr_byte;
      mdl_data_sent = 1'b0;
      mdl_retries   = mdl_retry_limit;
      mdl_step      = SEQ_START;
      r.action      = i2c_ras_pkg::ACT_START;
    end else if (it.op == i2c_ras_pkg::OP_STATUS && mdl_step != SEQ_IDLE) begin
      case (status)
        i2c_ras_pkg::ST_START: begin
          r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = addr_w; mdl_step = SEQ_SLA_W;
        end
        i2c_ras_pkg::ST_SLA_W_ACK: begin
          r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = mdl_reg_addr;
          mdl_step = SEQ_REG; mdl_data_sent = 1'b0;
        end
        i2c_ras_pkg::ST_DATA_ACK: begin
          if (mdl_data_sent) begin
            r.action = i2c_ras_pkg::ACT_STOP; r.done_res = 1'b1; mdl_step = SEQ_IDLE;
          end else if (mdl_is_write) begin
            r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = mdl_wr_byte;
            mdl_data_sent = 1'b1; mdl_step = SEQ_DATA;
          end else begin
            r.action = i2c_ras_pkg::ACT_START; mdl_step = SEQ_DATA;
          end
        end
        i2c_ras_pkg::ST_REP_START: begin
          r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = addr_w | 8'd1;
          mdl_step = SEQ_SLA_R;
        end
        i2c_ras_pkg::ST_SLA_R_ACK: begin
          r.action = i2c_ras_pkg::ACT_NACK; mdl_step = SEQ_RX;
        end
        i2c_ras_pkg::ST_DATA_NACK: begin
          r.action = i2c_ras_pkg::ACT_STOP; r.done_res = 1'b1; r.rd_data = it.rx_byte;
          mdl_step = SEQ_IDLE;
        end
        default: begin
          // Unexpected status: repeat the current step unless retries run out.
          mdl_retries = mdl_retries - 8'd1;
          if (mdl_retries == 8'd0) begin
            r.action = i2c_ras_pkg::ACT_STOP; r.done_res = 1'b1; r.failed = 1'b1;
            mdl_step = SEQ_IDLE;
          end else begin
            case (mdl_step)
              SEQ_START: r.action = i2c_ras_pkg::ACT_START;
              SEQ_SLA_W: begin
                r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = addr_w;
              end
              SEQ_REG: begin
                r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = mdl_reg_addr;
              end
              SEQ_DATA: begin
                if (mdl_is_write) begin
                  r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = mdl_wr_byte;
                end else begin
                  r.action = i2c_ras_pkg::ACT_START;
                end
              end
              SEQ_SLA_R: begin
                r.action = i2c_ras_pkg::ACT_SEND; r.tx_byte = addr_w | 8'd1;
              end
              SEQ_RX:    r.action = i2c_ras_pkg::ACT_NACK;
              default:   r.action = i2c_ras_pkg::ACT_NONE;
            endcase
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic i2c_ras_pkg::req_t random_item();
    i2c_ras_pkg::req_t it;
    it.op         = 2'($urandom_range(0, 3));
    it.reg_addr   = 8'($urandom_range(0, 255));
    it.wr_byte    = 8'($urandom_range(0, 255));
    it.bus_status = 8'($urandom_range(0, 255));
    it.rx_byte    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic i2c_ras_pkg::req_t start_item(input logic [1:0] op,
                                                   input logic [7:0] reg_addr,
                                                   input logic [7:0] wr_byte);
    i2c_ras_pkg::req_t it;
    it          = random_item();
    it.op       = op;
    it.reg_addr = reg_addr;
    it.wr_byte  = wr_byte;
    return it;
  endfunction

  function automatic i2c_ras_pkg::req_t status_item(input logic [7:0] status,
                                                    input logic [7:0] rx);
    i2c_ras_pkg::req_t it;
    it            = random_item();
    it.op         = i2c_ras_pkg::OP_STATUS;
    it.bus_status = status;
    it.rx_byte    = rx;
    return it;
  endfunction

  // Offers one item, waits for it to be taken and records what it should cause.
  task automatic send_item(input i2c_ras_pkg::req_t it);
    i2c_ras_pkg::rsp_t exp_rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    exp_rsp = predict_sequencer(it);
    expected_rsps.push_back(exp_rsp);
    sent_items++;
  endtask

  // Stops offering items and waits until every expected result has come out.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [i2c_ras_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == i2c_ras_pkg::CFG_SLAVE_ADDRESS) mdl_slave_addr = value[6:0];
    else mdl_retry_limit = value;
  endtask

  // One transfer in the proper status order, with random junk statuses mixed in
  // and the odd transfer dropped halfway so the next start abandons it.
  task automatic run_transfer(input int unsigned bad_pct);
    logic       is_wr;
    logic [7:0] code;
    is_wr = 1'($urandom_range(0, 1));
    send_item(start_item(is_wr ? i2c_ras_pkg::OP_WRITE : i2c_ras_pkg::OP_READ,
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    for (int k = 0; k < (is_wr ? 4 : 6); k++) begin
      if ($urandom_range(0, 99) < 3) return;
      while ($urandom_range(0, 99) < bad_pct)
        send_item(status_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      case (k)
        0:       code = i2c_ras_pkg::ST_START;
        1:       code = i2c_ras_pkg::ST_SLA_W_ACK;
        2:       code = i2c_ras_pkg::ST_DATA_ACK;
        3:       code = is_wr ? i2c_ras_pkg::ST_DATA_ACK : i2c_ras_pkg::ST_REP_START;
        4:       code = i2c_ras_pkg::ST_SLA_R_ACK;
        default: code = i2c_ras_pkg::ST_DATA_NACK;
      endcase
      send_item(status_item(code | 8'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_idle_and_unused_ops();
    // A status with nothing in progress and the spare op code both do nothing.
    send_item(status_item(i2c_ras_pkg::ST_START | 8'h07, 8'h00));
    send_item(start_item(OP_UNUSED, 8'hFF, 8'hFF));
    wait_drained();
  endtask

  task automatic test_register_write();
    // Reset address gives the write address byte of the reset device.
    send_item(start_item(i2c_ras_pkg::OP_WRITE, 8'hFF, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_START, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_SLA_W_ACK | 8'h07, 8'hFF));
    send_item(status_item(i2c_ras_pkg::ST_DATA_ACK, 8'h00));
    // The data byte acknowledged again closes the write with a stop.
    send_item(status_item(i2c_ras_pkg::ST_DATA_ACK | 8'h05, 8'h00));
    wait_drained();
  endtask

  task automatic test_register_read();
    send_item(start_item(i2c_ras_pkg::OP_READ, 8'h00, 8'hFF));
    send_item(status_item(i2c_ras_pkg::ST_START | 8'h07, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_SLA_W_ACK, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_DATA_ACK, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_REP_START, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_SLA_R_ACK, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_DATA_NACK, 8'hFF));
    wait_drained();
  endtask

  task automatic test_retry_exhausted();
    // One retry allowed: the first bad status already aborts. Bit 7 of the
    // address write is dropped by the block.
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd1);
    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'hFF);
    send_item(start_item(i2c_ras_pkg::OP_WRITE, 8'h5A, 8'hA5));
    send_item(status_item(i2c_ras_pkg::ST_START, 8'h00));
    send_item(status_item(8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_zero_retry_and_restart();
    // A zero limit wraps on the first bad status and keeps retrying.
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd0);
    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'h00);
    send_item(start_item(i2c_ras_pkg::OP_READ, 8'h3C, 8'h00));
    send_item(status_item(8'hFF, 8'h00));
    send_item(status_item(i2c_ras_pkg::ST_START, 8'h00));
    // A new start in the middle abandons the read.
    send_item(start_item(i2c_ras_pkg::OP_WRITE, 8'hC3, 8'hFF));
    send_item(status_item(i2c_ras_pkg::ST_DATA_ACK, 8'h00));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned target, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int unsigned bad_pct);
    int unsigned goal;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    goal = sent_items + target;
    while (sent_items < goal) begin
      if ($urandom_range(0, 99) < 85) run_transfer(bad_pct);
      else repeat ($urandom_range(1, 4)) send_item(random_item());
    end
    wait_drained();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
  endtask

  task automatic test_backpressure_fill();
    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills and stalls its input; then everything drains.
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd4);
    -> hold_off_go;
    repeat (6) run_transfer(10);
    wait_drained();
  endtask

  // Result checker: each taken result against the oldest expectation.
  always @(posedge clk) begin
    i2c_ras_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("result item with no expectation waiting: %h", rsp_item);
        err_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_item.action !== exp_rsp.action) begin
          $error("action: expected %0d, actual %0d", exp_rsp.action, rsp_item.action);
          err_count++;
        end
        if (rsp_item.tx_byte !== exp_rsp.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", exp_rsp.tx_byte, rsp_item.tx_byte);
          err_count++;
        end
        if (rsp_item.done_res !== exp_rsp.done_res) begin
          $error("done_res: expected %0d, actual %0d", exp_rsp.done_res, rsp_item.done_res);
          err_count++;
        end
        if (rsp_item.failed !== exp_rsp.failed) begin
          $error("failed: expected %0d, actual %0d", exp_rsp.failed, rsp_item.failed);
          err_count++;
        end
        if (rsp_item.rd_data !== exp_rsp.rd_data) begin
          $error("rd_data: expected %h, actual %h", exp_rsp.rd_data, rsp_item.rd_data);
          err_count++;
        end
      end
    end
  end

  // Receiver stall, random per cycle or held during a hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  always begin
    @(hold_off_go);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_unused_ops();
    test_register_write();
    test_register_read();
    test_retry_exhausted();
    test_zero_retry_and_restart();

    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd255);
    test_random_traffic(260, 0, 0, 8);

    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'h7F);
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd3);
    test_random_traffic(260, 49, 0, 25);

    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'h80);
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'd1);
    test_random_traffic(260, 0, 49, 10);

    write_reg(i2c_ras_pkg::CFG_SLAVE_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(i2c_ras_pkg::CFG_RETRY_LIMIT, 8'($urandom_range(2, 255)));
    test_random_traffic(260, 10, 10, 20);

    test_backpressure_fill();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected result items never arrived", expected_rsps.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
